/* rtl/core/spq_pkg.sv */
// Shared types and constants of the stable priority queue.
package spq_pkg;

  localparam int unsigned TagBits   = 16;
  localparam int unsigned PrioBits  = 8;
  localparam int unsigned CountBits = 5;

  typedef enum logic [1:0] {
    OP_PUSH   = 2'd0,
    OP_POP    = 2'd1,
    OP_CANCEL = 2'd2,
    OP_CLEAR  = 2'd3
  } spq_op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_FULL      = 2'd3
  } spq_status_e;

  typedef struct packed {
    logic [TagBits-1:0]  tag;
    logic [PrioBits-1:0] prio;
  } spq_entry_t;

  typedef struct packed {
    spq_op_e             operation;
    logic [TagBits-1:0]  call_tag;
    logic [PrioBits-1:0] call_priority;
  } spq_cmd_t;

  typedef struct packed {
    spq_status_e          status;
    logic [TagBits-1:0]   removed_tag;
    logic [PrioBits-1:0]  removed_priority;
    logic                 head_valid;
    logic [TagBits-1:0]   head_tag;
    logic [PrioBits-1:0]  head_priority;
    logic [CountBits-1:0] entry_count;
  } spq_result_t;

  typedef struct packed {
    spq_op_e    op;
    logic       go;
    spq_entry_t entry;
  } spq_ctrl_t;

  typedef struct packed {
    logic       valid;
    logic       stay;
    spq_entry_t entry;
  } spq_link_t;

  typedef struct packed {
    logic       valid;
    spq_entry_t entry;
  } spq_slot_t;

endpackage

/* rtl/core/spq_cell.sv */
// One storage cell of the sorted queue chain.
module spq_cell
  import spq_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  spq_ctrl_t ctrl_i,
  input  spq_link_t left_i,
  input  spq_link_t right_i,
  input  logic      hit_i,
  output spq_link_t link_o,
  output logic      hit_o,
  output logic      first_o,
  output spq_slot_t nxt_o
);

  logic       valid_q, valid_d;
  spq_entry_t entry_q, entry_d;
  logic       stay;
  logic       match;

  assign stay    = valid_q && (entry_q.prio <= ctrl_i.entry.prio);
  assign match   = valid_q && (entry_q.tag == ctrl_i.entry.tag);
  assign hit_o   = hit_i | match;
  assign first_o = match & ~hit_i;

  assign link_o = '{valid: valid_q, stay: stay, entry: entry_q};

  always_comb begin
    valid_d = valid_q;
    entry_d = entry_q;
    case (ctrl_i.op)
      OP_PUSH: begin
        if (ctrl_i.go && !stay) begin
          if (left_i.stay) begin
            valid_d = 1'b1;
            entry_d = ctrl_i.entry;
          end else begin
            valid_d = left_i.valid;
            entry_d = left_i.entry;
          end
        end
      end
      OP_POP: begin
        if (ctrl_i.go) begin
          valid_d = right_i.valid;
          entry_d = right_i.entry;
        end
      end
      OP_CANCEL: begin
        if (ctrl_i.go && hit_o) begin
          valid_d = right_i.valid;
          entry_d = right_i.entry;
        end
      end
      OP_CLEAR: begin
        if (ctrl_i.go) begin
          valid_d = 1'b0;
        end
      end
      default: ;
    endcase
  end

  assign nxt_o = '{valid: valid_d, entry: entry_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

/* rtl/core/stable_priority_queue.sv */
// Top level of the stable priority queue built as a chain of sorted cells.
//
//   channel   direction  signals                          transaction
//   command   in         start, busy, cmd_i               start high while busy low
//   result    out        result_valid_o, result_o         one cycle under result_valid_o
//
// A command is taken every cycle; busy stays low.
// Its result appears in the cycle after acceptance and lasts one cycle.
// All cells compare against the command at once and shift in the same cycle.
// Reset empties the queue; the cell contents are not cleared.
// The receiver cannot stall, so results are never held back.
module stable_priority_queue
  import spq_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  spq_cmd_t    cmd_i,
  output logic        result_valid_o,
  output spq_result_t result_o
);

  localparam int unsigned CountW = $clog2(DEPTH + 1);

  logic [CountW-1:0] count_q, count_d;
  logic              full, empty, accept, found;
  spq_ctrl_t         ctrl;
  spq_link_t         link  [DEPTH];
  spq_slot_t         nxt   [DEPTH];
  logic [DEPTH:0]    hit;
  logic [DEPTH-1:0]  first;
  logic [DEPTH-1:0]  valid_vec;
  spq_entry_t        cancel_entry;
  spq_entry_t        removed;
  spq_status_e       status;
  logic [CountW+CountBits-1:0] count_ext;
  spq_result_t       result_d, result_q;
  logic              result_valid_q;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = (count_q == CountW'(DEPTH));
  assign empty  = (count_q == '0);
  assign found  = hit[DEPTH];

  always_comb begin
    ctrl.op    = cmd_i.operation;
    ctrl.entry = '{tag: cmd_i.call_tag, prio: cmd_i.call_priority};
    case (cmd_i.operation)
      OP_PUSH:   ctrl.go = accept && !full;
      OP_POP:    ctrl.go = accept && !empty;
      OP_CANCEL: ctrl.go = accept;
      OP_CLEAR:  ctrl.go = accept;
      default:   ctrl.go = 1'b0;
    endcase
  end

  assign hit[0] = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    spq_link_t left_link, right_link;

    if (i == 0) begin : g_head
      assign left_link = '{valid: 1'b0, stay: 1'b1, entry: '0};
    end else begin : g_body
      assign left_link = link[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_link = '{valid: 1'b0, stay: 1'b0, entry: '0};
    end else begin : g_inner
      assign right_link = link[i+1];
    end

    spq_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl),
      .left_i (left_link),
      .right_i(right_link),
      .hit_i  (hit[i]),
      .link_o (link[i]),
      .hit_o  (hit[i+1]),
      .first_o(first[i]),
      .nxt_o  (nxt[i])
    );

    assign valid_vec[i] = link[i].valid;
  end

  always_comb begin
    cancel_entry = '0;
    for (int unsigned i = 0; i < DEPTH; i++) begin
      cancel_entry = cancel_entry | (first[i] ? link[i].entry : '0);
    end
  end

  always_comb begin
    count_d = count_q;
    removed = '0;
    status  = ST_OK;
    case (cmd_i.operation)
      OP_PUSH: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          count_d = count_q + CountW'(1);
        end
      end
      OP_POP: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          removed = link[0].entry;
          count_d = count_q - CountW'(1);
        end
      end
      OP_CANCEL: begin
        if (found) begin
          removed = cancel_entry;
          count_d = count_q - CountW'(1);
        end else begin
          status = ST_NOT_FOUND;
        end
      end
      OP_CLEAR: begin
        count_d = '0;
      end
      default: ;
    endcase
  end

  assign count_ext = {{CountBits{1'b0}}, count_d};

  always_comb begin
    result_d.status           = status;
    result_d.removed_tag      = removed.tag;
    result_d.removed_priority = removed.prio;
    result_d.head_valid       = nxt[0].valid;
    result_d.head_tag         = nxt[0].valid ? nxt[0].entry.tag : '0;
    result_d.head_priority    = nxt[0].valid ? nxt[0].entry.prio : '0;
    result_d.entry_count      = count_ext[CountBits-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q        <= '0;
      result_valid_q <= 1'b0;
    end else begin
      result_valid_q <= accept;
      if (accept) begin
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      result_q <= result_d;
    end
  end

  assign result_valid_o = result_valid_q;
  assign result_o       = result_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountW'(DEPTH))
    else $error("Occupancy exceeds the queue depth.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_vec) == int'(count_q))
    else $error("Occupied cells disagree with the occupancy count.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> result_valid_o)
    else $error("An accepted transaction produced no result.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && full && (cmd_i.operation == OP_PUSH) |=> $stable(count_q))
    else $error("A refused push changed the occupancy.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> $stable(valid_vec))
    else $error("Cells changed without an accepted transaction.");

endmodule

/* sim/call_queue_checker.sv */
`timescale 1ns / 100ps
// Checker that predicts each result of the stable priority queue and compares it on arrival.
module call_queue_checker
  import spq_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  spq_cmd_t    cmd_i,
  input  logic        result_valid_i,
  input  spq_result_t result_i,
  output int          mismatch_count_o,
  output int          awaiting_o
);

  logic [TagBits-1:0]  held_tags  [DEPTH];
  logic [PrioBits-1:0] held_prios [DEPTH];
  int unsigned         held = 0;
  spq_result_t         pending_results [4];
  logic [1:0]          pend_wr;
  logic [1:0]          pend_rd;
  int unsigned         pend_count;

  function automatic void drop_slot(int unsigned at);
    int unsigned i;
    for (i = at; i + 1 < held; i++) begin
      held_tags[i]  = held_tags[i + 1];
      held_prios[i] = held_prios[i + 1];
    end
    held--;
  endfunction

  function automatic spq_result_t serve_command(spq_cmd_t c);
    spq_result_t r;
    int unsigned i;
    int unsigned slot;
    r = '0;
    r.status = ST_OK;
    case (c.operation)
      OP_PUSH: begin
        if (held == DEPTH) begin
          r.status = ST_FULL;
        end else begin
          slot = 0;
          while (slot < held && held_prios[slot] <= c.call_priority) slot++;
          for (i = held; i > slot; i--) begin
            held_tags[i]  = held_tags[i - 1];
            held_prios[i] = held_prios[i - 1];
          end
          held_tags[slot]  = c.call_tag;
          held_prios[slot] = c.call_priority;
          held++;
        end
      end
      OP_POP: begin
        if (held == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.removed_tag      = held_tags[0];
          r.removed_priority = held_prios[0];
          drop_slot(0);
        end
      end
      OP_CANCEL: begin
        slot = 0;
        while (slot < held && held_tags[slot] != c.call_tag) slot++;
        if (slot == held) begin
          r.status = ST_NOT_FOUND;
        end else begin
          r.removed_tag      = held_tags[slot];
          r.removed_priority = held_prios[slot];
          drop_slot(slot);
        end
      end
      default: begin
        held = 0;
      end
    endcase
    if (held != 0) begin
      r.head_valid    = 1'b1;
      r.head_tag      = held_tags[0];
      r.head_priority = held_prios[0];
    end
    r.entry_count = CountBits'(held);
    return r;
  endfunction

  task automatic log_mismatch(string why, spq_result_t want, spq_result_t got);
    mismatch_count_o++;
    if (mismatch_count_o <= 10) begin
      $display("%0t %s: expected st=%0d rm=%h/%h hv=%b hd=%h/%h n=%0d",
               $time, why, want.status, want.removed_tag, want.removed_priority,
               want.head_valid, want.head_tag, want.head_priority, want.entry_count);
      $display("%0t %s: actual   st=%0d rm=%h/%h hv=%b hd=%h/%h n=%0d",
               $time, why, got.status, got.removed_tag, got.removed_priority,
               got.head_valid, got.head_tag, got.head_priority, got.entry_count);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    spq_result_t want;
    if (!rst_ni) begin
      held = 0;
      pend_wr = '0;
      pend_rd = '0;
      pend_count = 0;
      mismatch_count_o = 0;
      awaiting_o = 0;
    end else begin
      if (start_i && !busy_i) begin
        pending_results[pend_wr] = serve_command(cmd_i);
        pend_wr++;
        pend_count++;
      end
      if (result_valid_i) begin
        if (pend_count == 0) begin
          log_mismatch("result with no transaction outstanding", '0, result_i);
        end else begin
          want = pending_results[pend_rd];
          pend_rd++;
          pend_count--;
          if (result_i.status !== want.status ||
              result_i.removed_tag !== want.removed_tag ||
              result_i.removed_priority !== want.removed_priority ||
              result_i.head_valid !== want.head_valid ||
              result_i.head_tag !== want.head_tag ||
              result_i.head_priority !== want.head_priority ||
              result_i.entry_count !== want.entry_count) begin
            log_mismatch("wrong result", want, result_i);
          end
        end
      end
      awaiting_o = int'(pend_count);
    end
  end

endmodule

/* sim/stable_priority_queue_tb.sv */
`timescale 1ns / 100ps
// Testbench top that drives call queue commands and reports the verdict of the checker.
module stable_priority_queue_tb;
  import spq_pkg::*;

  localparam int unsigned Depth = 16;
  localparam int RandomCalls = 2000;
  localparam int CycleLimit = 1000000;
  localparam int unsigned CmdBits = $bits(spq_cmd_t);

  typedef enum {FILLING, DRAINING, MIXED} load_e;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  spq_cmd_t    cmd;
  logic        result_valid;
  spq_result_t result;
  int          mismatch_count;
  int          awaiting;
  int          cycles = 0;

  stable_priority_queue #(
    .DEPTH(Depth)
  ) uut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .start(start),
    .busy(busy),
    .cmd_i(cmd),
    .result_valid_o(result_valid),
    .result_o(result)
  );

  call_queue_checker #(
    .DEPTH(Depth)
  ) checker_i (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .start_i(start),
    .busy_i(busy),
    .cmd_i(cmd),
    .result_valid_i(result_valid),
    .result_i(result),
    .mismatch_count_o(mismatch_count),
    .awaiting_o(awaiting)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("stable_priority_queue: mismatch");
      $finish;
    end
  end

  task automatic send_call(spq_op_e op, logic [TagBits-1:0] tag, logic [PrioBits-1:0] prio);
    spq_cmd_t c;
    c.operation     = op;
    c.call_tag      = tag;
    c.call_priority = prio;
    @(negedge clk_i);
    start <= 1'b1;
    cmd   <= c;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic pause(int cycles_idle);
    logic [CmdBits-1:0] noise;
    if (cycles_idle > 0) begin
      noise = CmdBits'($urandom);
      @(negedge clk_i);
      start <= 1'b0;
      cmd   <= noise;
      repeat (cycles_idle - 1) @(negedge clk_i);
    end
  endtask

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) begin
      return 0;
    end else if (roll < 88) begin
      return $urandom_range(1, 3);
    end else if (roll < 98) begin
      return $urandom_range(4, 12);
    end else begin
      return $urandom_range(20, 60);
    end
  endfunction

  initial begin
    int k;
    int roll;
    int push_cut;
    int pop_cut;
    bit steady;
    load_e load;
    spq_op_e op;
    logic [TagBits-1:0] tag;
    logic [PrioBits-1:0] prio;

    rst_ni = 1'b0;
    start  = 1'b0;
    cmd    = '0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    send_call(OP_POP, 16'h0000, 8'h00);
    send_call(OP_CANCEL, 16'hFFFF, 8'hFF);
    send_call(OP_PUSH, 16'h0000, 8'h80);
    send_call(OP_PUSH, 16'hFFFF, 8'h80);
    send_call(OP_PUSH, 16'h1234, 8'h00);
    send_call(OP_PUSH, 16'hABCD, 8'hFF);
    send_call(OP_PUSH, 16'h1234, 8'h80);
    send_call(OP_PUSH, 16'h5A5A, 8'h00);
    send_call(OP_CANCEL, 16'h1234, 8'h00);
    send_call(OP_CANCEL, 16'h9999, 8'h00);
    send_call(OP_POP, 16'h0000, 8'h00);
    for (k = 0; k < 12; k++) begin
      send_call(OP_PUSH, 16'(16'h0100 + k), 8'(240 - 20 * k));
    end
    send_call(OP_PUSH, 16'h7777, 8'h01);
    send_call(OP_CLEAR, 16'hFFFF, 8'hFF);
    send_call(OP_POP, 16'h0000, 8'h00);

    load = MIXED;
    steady = 1'b0;
    for (k = 0; k < RandomCalls; k++) begin
      if (k % 64 == 0) begin
        load = load_e'($urandom_range(0, 2));
        steady = ($urandom_range(0, 3) == 0);
      end
      case (load)
        FILLING: begin
          push_cut = 70;
          pop_cut  = 85;
        end
        DRAINING: begin
          push_cut = 25;
          pop_cut  = 70;
        end
        default: begin
          push_cut = 45;
          pop_cut  = 72;
        end
      endcase
      roll = $urandom_range(0, 99);
      if (roll < push_cut) begin
        op = OP_PUSH;
      end else if (roll < pop_cut) begin
        op = OP_POP;
      end else if (roll < 98) begin
        op = OP_CANCEL;
      end else begin
        op = OP_CLEAR;
      end
      tag = ($urandom_range(0, 9) < 7) ? TagBits'($urandom_range(0, 15)) : TagBits'($urandom);
      roll = $urandom_range(0, 9);
      if (roll < 6) begin
        prio = PrioBits'($urandom_range(0, 7));
      end else if (roll < 9) begin
        prio = PrioBits'($urandom);
      end else begin
        prio = $urandom_range(0, 1) ? '1 : '0;
      end
      if (!steady) begin
        pause(pick_gap());
      end
      send_call(op, tag, prio);
    end

    @(negedge clk_i);
    start <= 1'b0;
    while (awaiting != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    if (mismatch_count == 0) begin
      $display("stable_priority_queue: match");
    end else begin
      $display("stable_priority_queue: mismatch");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/spq_pkg.sv
rtl/core/spq_cell.sv
rtl/core/stable_priority_queue.sv
sim/call_queue_checker.sv
sim/stable_priority_queue_tb.sv
